[rtl/core/mis_pkg.sv]
// motion integrator step: shared types, constants and the fixed-point helper
// depends on nothing; used by every module of the core
`timescale 1ns / 1ps

package mis_pkg;

    // data widths
    localparam int DATA_W       = 32;
    localparam int STEP_W       = 26;
    localparam int PROD_W       = DATA_W + STEP_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int TS_W         = 24;
    localparam int METHOD_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = TS_W;
    localparam int NUM_AXES     = 3;
    localparam int FRAC_BITS_DEF = 16;

    // forest-ruth coefficients, scaled by 2^COEF_SHIFT
    localparam int COEF_SHIFT = 30;
    localparam int COEF_W     = 32;
    localparam int COEF_PROD_W = TS_W + 1 + COEF_W;
    localparam logic signed [COEF_W-1:0] FR_THETA = 32'sd1450847675;
    localparam logic signed [COEF_W-1:0] FR_MID   = -32'sd1827953526;

    // saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // register reset values
    localparam logic [TS_W-1:0]     TIME_STEP_RST = 24'd6554;

    // method codes
    localparam logic [METHOD_W-1:0] METHOD_LEAPFROG    = 2'd0;
    localparam logic [METHOD_W-1:0] METHOD_FOREST_RUTH = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_SEMI_EULER  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_METHOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIME_STEP = 2'd1;

    // input word
    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic signed [DATA_W-1:0] acc_x;
        logic signed [DATA_W-1:0] acc_y;
        logic signed [DATA_W-1:0] acc_z;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_pos_z;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic signed [DATA_W-1:0] new_vel_z;
    } t_out_word;

    // particle state inside the pipe, indexed by axis
    typedef struct packed {
        logic [NUM_AXES-1:0][DATA_W-1:0] pos;
        logic [NUM_AXES-1:0][DATA_W-1:0] vel;
        logic [NUM_AXES-1:0][DATA_W-1:0] acc;
    } t_axes_word;

    // step lengths of one leapfrog substep: first drift, kick, second drift
    typedef struct packed {
        logic signed [STEP_W-1:0] drift_a;
        logic signed [STEP_W-1:0] kick;
        logic signed [STEP_W-1:0] drift_b;
    } t_step_set;

    // base + round(prod / 2^shift), ties up, saturated to 32 bits
    function automatic logic [DATA_W-1:0] add_round_sat(
        input logic [DATA_W-1:0]        base,
        input logic signed [PROD_W-1:0] prod,
        input int unsigned              shift
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] rounded;
        logic signed [SUM_W-1:0]  sum;
        logic [DATA_W-1:0]        result;
        half    = PROD_W'(1) << (shift - 1);
        rounded = (prod + half) >>> shift;
        sum     = SUM_W'($signed(base)) + SUM_W'(rounded);
        if (&sum[SUM_W-1:DATA_W-1] || ~|sum[SUM_W-1:DATA_W-1]) begin
            result = sum[DATA_W-1:0];
        end else begin
            result = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end
        return result;
    endfunction

endpackage

[rtl/core/motion_integrator_step_core.sv]
// Advances one particle by one time step (leapfrog, Forest-Ruth or
// semi-implicit Euler, Q16.16 with saturation). A new word is taken every
// cycle while the input is not stalled: the input register takes the word,
// then three leapfrog substeps of four stages each (multiply,
// round-add-saturate, multiply, round-add-saturate) carry it to the output.
// The three chained substeps of Forest-Ruth set that depth; the other
// methods run through the same stages with zero-length substeps. A stall
// only holds stages that are full, so bubbles close up. The user must write
// method and time step only while the pipe is empty; the block does not
// enforce this. The derived Forest-Ruth lengths are registered from the
// stored time step.
// depends on mis_pkg, mis_step_gen, mis_substep
`timescale 1ns / 1ps

module motion_integrator_step_core #(
    parameter int FRAC_BITS = mis_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  mis_pkg::t_in_word              i_in_word,
    output logic                           o_valid,
    input  logic                           i_stall,
    output mis_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mis_pkg::t_step_set [2:0] w_steps;

    logic                r_in_valid;
    mis_pkg::t_axes_word r_in_word, n_in_word;
    logic                w_in_en;

    logic                w_sub_valid [4];
    logic                w_sub_stall [4];
    mis_pkg::t_axes_word w_sub_word  [4];

    // configuration and substep lengths
    mis_step_gen u_step_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_steps     (w_steps)
    );

    // input register
    assign w_in_en = !r_in_valid || !w_sub_stall[0];
    assign o_stall = !i_rst_n || !w_in_en;

    always_comb begin
        n_in_word        = '0;
        n_in_word.pos[0] = i_in_word.pos_x;
        n_in_word.pos[1] = i_in_word.pos_y;
        n_in_word.pos[2] = i_in_word.pos_z;
        n_in_word.vel[0] = i_in_word.vel_x;
        n_in_word.vel[1] = i_in_word.vel_y;
        n_in_word.vel[2] = i_in_word.vel_z;
        n_in_word.acc[0] = i_in_word.acc_x;
        n_in_word.acc[1] = i_in_word.acc_y;
        n_in_word.acc[2] = i_in_word.acc_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_en) r_in_word <= n_in_word;
    end

    assign w_sub_valid[0] = r_in_valid;
    assign w_sub_word[0]  = r_in_word;
    assign w_sub_stall[3] = i_stall;

    // three chained substeps
    for (genvar g = 0; g < 3; g++) begin : g_sub
        mis_substep #(
            .FRAC_BITS (FRAC_BITS)
        ) u_substep (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sub_valid[g]),
            .o_stall (w_sub_stall[g]),
            .i_word  (w_sub_word[g]),
            .i_steps (w_steps[g]),
            .o_valid (w_sub_valid[g+1]),
            .i_stall (w_sub_stall[g+1]),
            .o_word  (w_sub_word[g+1])
        );
    end

    // result word
    assign o_valid              = w_sub_valid[3];
    assign o_out_word.new_pos_x = w_sub_word[3].pos[0];
    assign o_out_word.new_pos_y = w_sub_word[3].pos[1];
    assign o_out_word.new_pos_z = w_sub_word[3].pos[2];
    assign o_out_word.new_vel_x = w_sub_word[3].vel[0];
    assign o_out_word.new_vel_y = w_sub_word[3].vel[1];
    assign o_out_word.new_vel_z = w_sub_word[3].vel[2];

endmodule

[rtl/core/mis_step_gen.sv]
// motion integrator step: configuration registers and substep length selection
// depends on mis_pkg
`timescale 1ns / 1ps

module mis_step_gen (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mis_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mis_pkg::t_step_set [2:0]           o_steps
);

    localparam int STEP_W = mis_pkg::STEP_W;
    localparam int CPW    = mis_pkg::COEF_PROD_W;

    logic [mis_pkg::METHOD_W-1:0] r_method;
    logic [mis_pkg::TS_W-1:0]     r_time_step;
    logic signed [STEP_W-1:0]     r_dt_outer;
    logic signed [STEP_W-1:0]     r_dt_mid;

    logic signed [CPW-1:0] w_prod_outer;
    logic signed [CPW-1:0] w_prod_mid;
    logic signed [CPW-1:0] w_round_outer;
    logic signed [CPW-1:0] w_round_mid;
    logic signed [STEP_W-1:0] w_dt;
    logic signed [STEP_W-1:0] w_dt2;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method    <= mis_pkg::METHOD_LEAPFROG;
            r_time_step <= mis_pkg::TIME_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mis_pkg::CFG_IDX_METHOD: begin
                    r_method <= i_cfg_data[mis_pkg::METHOD_W-1:0];
                end
                mis_pkg::CFG_IDX_TIME_STEP: begin
                    r_time_step <= i_cfg_data[mis_pkg::TS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // forest-ruth substep lengths, one multiply and round each
    assign w_prod_outer  = CPW'($signed({1'b0, r_time_step})) * CPW'(mis_pkg::FR_THETA);
    assign w_prod_mid    = CPW'($signed({1'b0, r_time_step})) * CPW'(mis_pkg::FR_MID);
    assign w_round_outer = (w_prod_outer + (CPW'(1) << (mis_pkg::COEF_SHIFT - 1)))
                           >>> mis_pkg::COEF_SHIFT;
    assign w_round_mid   = (w_prod_mid + (CPW'(1) << (mis_pkg::COEF_SHIFT - 1)))
                           >>> mis_pkg::COEF_SHIFT;

    always_ff @(posedge i_clk) begin
        r_dt_outer <= w_round_outer[STEP_W-1:0];
        r_dt_mid   <= w_round_mid[STEP_W-1:0];
    end

    assign w_dt  = STEP_W'({1'b0, r_time_step});
    assign w_dt2 = STEP_W'({r_time_step, 1'b0});

    // per-method lengths; a zero length makes a substep pass its word through
    always_comb begin
        o_steps = '0;
        unique case (r_method)
            mis_pkg::METHOD_FOREST_RUTH: begin
                o_steps[0] = '{drift_a: r_dt_outer, kick: r_dt_outer, drift_b: r_dt_outer};
                o_steps[1] = '{drift_a: r_dt_mid, kick: r_dt_mid, drift_b: r_dt_mid};
                o_steps[2] = '{drift_a: r_dt_outer, kick: r_dt_outer, drift_b: r_dt_outer};
            end
            mis_pkg::METHOD_SEMI_EULER: begin
                // kick, then a full drift written as a half drift of twice the step
                o_steps[0] = '{drift_a: '0, kick: w_dt, drift_b: w_dt2};
            end
            mis_pkg::METHOD_LEAPFROG: begin
                o_steps[0] = '{drift_a: w_dt, kick: w_dt, drift_b: w_dt};
            end
            default: begin
                // unused code runs as leapfrog
                o_steps[0] = '{drift_a: w_dt, kick: w_dt, drift_b: w_dt};
            end
        endcase
    end

endmodule

[rtl/core/mis_substep.sv]
// motion integrator step: one leapfrog substep in four register stages
// depends on mis_pkg
`timescale 1ns / 1ps

module mis_substep #(
    parameter int FRAC_BITS = mis_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  mis_pkg::t_axes_word   i_word,
    input  mis_pkg::t_step_set    i_steps,
    output logic                  o_valid,
    input  logic                  i_stall,
    output mis_pkg::t_axes_word   o_word
);

    localparam int PW = mis_pkg::PROD_W;
    localparam int NA = mis_pkg::NUM_AXES;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    // stage payloads
    mis_pkg::t_axes_word      r_s1, n_s1;
    logic signed [PW-1:0]     r_s1_prod_d [NA];
    logic signed [PW-1:0]     n_s1_prod_d [NA];
    logic signed [PW-1:0]     r_s1_prod_k [NA];
    logic signed [PW-1:0]     n_s1_prod_k [NA];
    mis_pkg::t_axes_word      r_s2, n_s2;
    mis_pkg::t_axes_word      r_s3, n_s3;
    logic signed [PW-1:0]     r_s3_prod [NA];
    logic signed [PW-1:0]     n_s3_prod [NA];
    mis_pkg::t_axes_word      r_s4, n_s4;

    // a stage moves when it is empty or the next one moves
    assign w_en4   = !r_v4 || !i_stall;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v4;
    assign o_word  = r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: first drift product and kick product
    always_comb begin
        n_s1 = i_word;
        for (int k = 0; k < NA; k++) begin
            n_s1_prod_d[k] = PW'($signed(i_word.vel[k])) * PW'(i_steps.drift_a);
            n_s1_prod_k[k] = PW'($signed(i_word.acc[k])) * PW'(i_steps.kick);
        end
    end

    // stage 2: apply half drift and kick
    always_comb begin
        n_s2 = r_s1;
        for (int k = 0; k < NA; k++) begin
            n_s2.pos[k] = mis_pkg::add_round_sat(r_s1.pos[k], r_s1_prod_d[k], FRAC_BITS + 1);
            n_s2.vel[k] = mis_pkg::add_round_sat(r_s1.vel[k], r_s1_prod_k[k], FRAC_BITS);
        end
    end

    // stage 3: second drift product with the new velocity
    always_comb begin
        n_s3 = r_s2;
        for (int k = 0; k < NA; k++) begin
            n_s3_prod[k] = PW'($signed(r_s2.vel[k])) * PW'(i_steps.drift_b);
        end
    end

    // stage 4: apply second half drift
    always_comb begin
        n_s4 = r_s3;
        for (int k = 0; k < NA; k++) begin
            n_s4.pos[k] = mis_pkg::add_round_sat(r_s3.pos[k], r_s3_prod[k], FRAC_BITS + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1        <= n_s1;
            r_s1_prod_d <= n_s1_prod_d;
            r_s1_prod_k <= n_s1_prod_k;
        end
        if (w_en2) r_s2 <= n_s2;
        if (w_en3) begin
            r_s3      <= n_s3;
            r_s3_prod <= n_s3_prod;
        end
        if (w_en4) r_s4 <= n_s4;
    end

endmodule

[rtl/core/mis_checker.sv]
// motion integrator step: port checks over time, bound to the top level
// depends on mis_pkg and motion_integrator_step_core
`timescale 1ns / 1ps

module mis_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input mis_pkg::t_in_word              i_in_word,
    input logic                           o_valid,
    input logic                           i_stall,
    input mis_pkg::t_out_word             o_out_word,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [mis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [mis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result word stays and does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // without back-pressure at the output, the input is never stalled
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while the output can move");

    // input stall only follows a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_stall |-> o_valid && i_stall)
        else $error("input stalled with no held result");

endmodule

bind motion_integrator_step_core mis_checker u_mis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_in_word   (i_in_word),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_word  (o_out_word),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);
